/* sv/disparity_to_xyz_defines.svh */
// Assertion macros used by the checker file.
`ifndef DISPARITY_TO_XYZ_DEFINES_SVH
`define DISPARITY_TO_XYZ_DEFINES_SVH
// Implication check with asynchronous reset disable.
`define D2X_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication check.
`define D2X_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/d2x_pkg.sv */
// Package: widths and constants for the disparity reprojection block.
`default_nettype none
package d2x_pkg;
  localparam int unsigned OutW = 48;
  localparam logic [47:0] SentinelQ16 = 48'd655360000000;
  localparam logic [11:0] DispMask = 12'hFFF;
  typedef enum logic [2:0] {
    RegFormat   = 3'd0,
    RegBaseline = 3'd1,
    RegFocal    = 3'd2,
    RegCenterX  = 3'd3,
    RegCenterY  = 3'd4
  } reg_idx_e;
endpackage
`default_nettype wire

/* sv/d2x_div.sv */
// Pipelined restoring divider: one quotient bit per stage, one item per cycle.
`default_nettype none
module d2x_div #(
  parameter int unsigned NumW = 52,
  parameter int unsigned DenW = 16
) (
  input  wire logic            clk_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic      [NumW-1:0] quo_o
);
  // stage k holds partial remainder, remaining numerator bits and quotient
  logic [DenW:0]   rem_q [NumW+1];
  logic [NumW-1:0] num_q [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];

  always_comb begin
    rem_q[0] = '0;
    num_q[0] = num_i;
    den_q[0] = den_i;
  end

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW+1:0] trial;
    logic [DenW+1:0] diff;
    always_comb begin
      trial = {rem_q[k], num_q[k][NumW-1]};
      diff  = trial - {2'b00, den_q[k]};
    end
    always_ff @(posedge clk_i) begin
      den_q[k+1] <= den_q[k];
      if (!diff[DenW+1]) begin
        rem_q[k+1] <= diff[DenW:0];
        num_q[k+1] <= {num_q[k][NumW-2:0], 1'b1};
      end else begin
        rem_q[k+1] <= trial[DenW:0];
        num_q[k+1] <= {num_q[k][NumW-2:0], 1'b0};
      end
    end
  end
  // the numerator shifts out while quotient bits shift in
  assign quo_o = num_q[NumW];
endmodule
`default_nettype wire

/* sv/disparity_to_xyz.sv */
// Top level: stereo disparity to 3D point reprojection pipeline.
//
//  channel | signals                                    | transfer when
//  --------+--------------------------------------------+-------------------
//  command | start_i, busy_o, pixel_col/row, raw_disp.  | start_i & !busy_o
//  result  | done_o, dist_x/y/z_o, invalid_o            | done_o (no stall)
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i           | cfg_we_i
//
// One item may enter every cycle; busy_o is always low.
// The pipe is an offset stage, a product stage, then one
// quotient bit per stage in three parallel long-division pipes (NUM_W deep).
// Reset clears valid bits and config (format bit set to 1); payload stages hold none.
// The receiver cannot stall, so nothing in the pipe ever waits.
`default_nettype none
module disparity_to_xyz #(
  parameter int unsigned DISP_FRAC_BITS = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [11:0] pixel_col_i,
  input  wire logic [11:0] pixel_row_i,
  input  wire logic [15:0] raw_disparity_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_wdata_i,
  output logic             done_o,
  output logic signed [47:0] dist_x_o,
  output logic signed [47:0] dist_y_o,
  output logic signed [47:0] dist_z_o,
  output logic             invalid_o
);
  // magnitudes: B*|p-c| < 2^36, B*f < 2^40; shifted by F
  localparam int unsigned NUM_W = 40 + DISP_FRAC_BITS;
  localparam int unsigned Lat = NUM_W + 2;

  // configuration registers
  logic        fmt_q;
  logic [23:0] base_q;
  logic [15:0] foc_q;
  logic [11:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= 1'b1;
      base_q <= '0;
      foc_q  <= '0;
      cx_q   <= '0;
      cy_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        d2x_pkg::RegFormat:   fmt_q  <= cfg_wdata_i[0];
        d2x_pkg::RegBaseline: base_q <= cfg_wdata_i;
        d2x_pkg::RegFocal:    foc_q  <= cfg_wdata_i[15:0];
        d2x_pkg::RegCenterX:  cx_q   <= cfg_wdata_i[11:0];
        d2x_pkg::RegCenterY:  cy_q   <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;
  logic take;
  assign take = start_i;

  // stage 1: offsets and sign, sentinel decision
  logic [11:0] mx_q, my_q, d1_q;
  logic        nx_q, ny_q, bad1_q;
  logic [11:0] dmask;
  assign dmask = raw_disparity_i[11:0] & d2x_pkg::DispMask;
  always_ff @(posedge clk_i) begin
    nx_q   <= pixel_col_i < cx_q;
    ny_q   <= pixel_row_i < cy_q;
    mx_q   <= (pixel_col_i < cx_q) ? cx_q - pixel_col_i : pixel_col_i - cx_q;
    my_q   <= (pixel_row_i < cy_q) ? cy_q - pixel_row_i : pixel_row_i - cy_q;
    d1_q   <= dmask;
    bad1_q <= !fmt_q || (dmask == '0);
  end

  // stage 2: products (each 24x16 or smaller)
  logic [35:0] px_q, py_q;
  logic [39:0] pz_q;
  logic [11:0] d2_q;
  logic        nx2_q, ny2_q, bad2_q;
  always_ff @(posedge clk_i) begin
    px_q   <= base_q * mx_q;
    py_q   <= base_q * my_q;
    pz_q   <= base_q * foc_q;
    d2_q   <= d1_q;
    nx2_q  <= nx_q;
    ny2_q  <= ny_q;
    bad2_q <= bad1_q;
  end

  // divider numerators; bad items use a divisor of one to stay defined
  logic [NUM_W-1:0] numx, numy, numz, qx, qy, qz;
  logic [15:0]      denl, denz;
  assign numx = NUM_W'({px_q, DISP_FRAC_BITS'(0)});
  assign numy = NUM_W'({py_q, DISP_FRAC_BITS'(0)});
  assign numz = {pz_q, DISP_FRAC_BITS'(0)};
  assign denl = bad2_q ? 16'd1 : {4'd0, d2_q};
  assign denz = bad2_q ? 16'd1 : {d2_q, 4'd0};

  d2x_div #(.NumW(NUM_W), .DenW(16)) u_div_x (.clk_i, .num_i(numx), .den_i(denl), .quo_o(qx));
  d2x_div #(.NumW(NUM_W), .DenW(16)) u_div_y (.clk_i, .num_i(numy), .den_i(denl), .quo_o(qy));
  d2x_div #(.NumW(NUM_W), .DenW(16)) u_div_z (.clk_i, .num_i(numz), .den_i(denz), .quo_o(qz));

  // side pipe for sign and sentinel flags, aligned with the dividers
  logic [NUM_W-1:0] sx_q, sy_q, sb_q;
  always_ff @(posedge clk_i) begin
    sx_q <= {sx_q[NUM_W-2:0], nx2_q};
    sy_q <= {sy_q[NUM_W-2:0], ny2_q};
    sb_q <= {sb_q[NUM_W-2:0], bad2_q};
  end

  // valid bits travel with the data
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[Lat-2:0], take};
  end

  logic [47:0] ux, uy, uz;
  assign ux = 48'(qx);
  assign uy = 48'(qy);
  assign uz = 48'(qz);
  logic bad;
  assign bad = sb_q[NUM_W-1];

  assign done_o    = vld_q[Lat-1];
  assign invalid_o = bad;
  assign dist_x_o  = bad ? d2x_pkg::SentinelQ16 : (sx_q[NUM_W-1] ? -ux : ux);
  assign dist_y_o  = bad ? d2x_pkg::SentinelQ16 : (sy_q[NUM_W-1] ? -uy : uy);
  assign dist_z_o  = bad ? d2x_pkg::SentinelQ16 : uz;

  logic unused;
  assign unused = ^raw_disparity_i[15:12];
endmodule
`default_nettype wire

/* sv/disparity_to_xyz_chk.sv */
// Port-level checker for the reprojection block, bound to the top level.
`default_nettype none
`include "disparity_to_xyz_defines.svh"
module disparity_to_xyz_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic        invalid_o,
  input wire logic [47:0] dist_x_o,
  input wire logic [47:0] dist_y_o,
  input wire logic [47:0] dist_z_o
);
  `D2X_ASSERT_IMP(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o)
  `D2X_ASSERT_IMP(a_sentinel, clk_i, rst_ni, done_o && invalid_o,
    dist_x_o == 48'd655360000000 && dist_y_o == 48'd655360000000 && dist_z_o == 48'd655360000000)
  `D2X_ASSERT_IMP(a_z_sign, clk_i, rst_ni, done_o && !invalid_o, !dist_z_o[47])
endmodule
bind disparity_to_xyz disparity_to_xyz_chk u_chk (.*);
`default_nettype wire
